// ===== sv/golay24_codec_assert.svh =====
// Assertion macros for the Golay codec. Both forms check on the rising edge of clk_i.
// G24C_ASSERT is disabled while rst_ni is low.
// G24C_ASSERT_RST also checks during reset.
`ifndef GOLAY24_CODEC_ASSERT_SVH
`define GOLAY24_CODEC_ASSERT_SVH
`ifndef SYNTHESIS
`define G24C_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("golay24_codec check failed");
`define G24C_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("golay24_codec reset check failed");
`else
`define G24C_ASSERT(name, prop)
`define G24C_ASSERT_RST(name, prop)
`endif
`endif

// ===== sv/g24c_pkg.sv =====
package g24c_pkg;

  localparam int unsigned HalfW = 12;
  localparam int unsigned WordW = 2 * HalfW;

  typedef logic [HalfW-1:0] half_t;
  typedef logic [WordW-1:0] word_t;

  typedef enum logic {
    FUNC_ENCODE = 1'b0,
    FUNC_DECODE = 1'b1
  } func_e;

  // Rows of the parity matrix B.
  localparam half_t GolayB [HalfW] = '{
    12'h7ff, 12'hee2, 12'hdc5, 12'hb8b, 12'hf16, 12'he2d,
    12'hc5b, 12'h8b7, 12'h96e, 12'hadc, 12'hdb8, 12'hb71
  };

  // Beat handed from the front half of the pipeline to the back half.
  typedef struct packed {
    func_e func;
    half_t hi;
    half_t lo;
    half_t pv;
    half_t s;
    half_t q;
    logic  c1;
    half_t m2;
  } mid_t;

  // Bit 11-i of the product is the parity of v AND row i.
  function automatic half_t mul_b(half_t v);
    half_t acc;
    acc = '0;
    for (int i = 0; i < HalfW; i++) begin
      acc[HalfW-1-i] = ^(v & GolayB[i]);
    end
    return acc;
  endfunction

  // Number of set bits in a 12-bit value.
  function automatic logic [3:0] weight(half_t v);
    logic [3:0] n;
    n = '0;
    for (int k = 0; k < HalfW; k++) begin
      n = n + 4'(v[k]);
    end
    return n;
  endfunction

endpackage

// ===== sv/g24c_if.sv =====
interface g24c_in_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [g24c_pkg::WordW-1:0]  data_word;

  modport source (output valid, output func, output data_word, input ready);
  modport sink   (input valid, input func, input data_word, output ready);
endinterface

interface g24c_out_if;
  logic                        valid;
  logic                        ready;
  logic [g24c_pkg::WordW-1:0]  result_word;
  logic                        ok;

  modport source (output valid, output result_word, output ok, input ready);
  modport sink   (input valid, input result_word, input ok, output ready);
endinterface

// ===== sv/golay24_codec.sv =====
// Extended Golay (24,12,8) codec, encode or decode chosen per beat.
// Input channel in_i: func (0 encode, 1 decode) and data_word. Encode takes the
// message from data_word[11:0] and returns message<<12 | parity with ok = 1.
// Decode corrects up to three bit errors and returns the message in
// result_word[11:0]; an uncorrectable word returns 0 with ok = 0.
// Output channel out_o: result_word and ok, one result beat per input beat,
// in input order.
// The result passes through four register stages (parity product, syndrome
// tests, second syndrome tests, output register) before it shows on out_o.
// Throughput is one beat per cycle while the receiver keeps ready high; each
// stage can take a new beat as its last one moves on.
// Each stage carries its own valid bit and takes a new beat whenever it is
// empty or its beat moves on, so bubbles close up behind a stall.
// When the receiver holds ready low the result stays on out_o unchanged and
// the stages behind it keep filling; in_i.ready drops once all four are full.
// Reset (rst_ni low, asynchronous) empties every stage; nothing else is kept.
module golay24_codec (
  input  logic        clk_i,
  input  logic        rst_ni,
  g24c_in_if.sink     in_i,
  g24c_out_if.source  out_o
);

  logic            mid_valid;
  logic            mid_ready;
  g24c_pkg::mid_t  mid;

  // Stages 1 and 2.
  g24c_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_i.valid),
    .ready_o     (in_i.ready),
    .func_i      (in_i.func),
    .word_i      (in_i.data_word),
    .mid_valid_o (mid_valid),
    .mid_ready_i (mid_ready),
    .mid_o       (mid)
  );

  // Stages 3 and 4.
  g24c_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_valid_i (mid_valid),
    .mid_ready_o (mid_ready),
    .mid_i       (mid),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .result_o    (out_o.result_word),
    .ok_o        (out_o.ok)
  );

endmodule

// ===== sv/g24c_front.sv =====
// Front half: stage 1 forms the parity product of the low half, stage 2 forms the
// syndrome, the first two weight tests and the second syndrome.
module g24c_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic              func_i,
  input  g24c_pkg::word_t   word_i,
  output logic              mid_valid_o,
  input  logic              mid_ready_i,
  output g24c_pkg::mid_t    mid_o
);

  logic              s1_valid_q;
  logic              s1_ready;
  g24c_pkg::func_e   fn1_q;
  g24c_pkg::half_t   hi1_q;
  g24c_pkg::half_t   lo1_q;
  g24c_pkg::half_t   pv1_q;

  logic              s2_valid_q;
  logic              s2_ready;
  g24c_pkg::mid_t    mid_d;
  g24c_pkg::mid_t    mid_q;

  // A stage takes a new beat when it is empty or its beat moves on.
  assign s2_ready = !s2_valid_q || mid_ready_i;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign ready_o  = s1_ready;

  // Stage 1 valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= valid_i;
    end
  end

  // Stage 1 payload: split the word and form the parity of the low half.
  always_ff @(posedge clk_i) begin
    if (s1_ready && valid_i) begin
      fn1_q <= g24c_pkg::func_e'(func_i);
      hi1_q <= word_i[g24c_pkg::WordW-1:g24c_pkg::HalfW];
      lo1_q <= word_i[g24c_pkg::HalfW-1:0];
      pv1_q <= g24c_pkg::mul_b(word_i[g24c_pkg::HalfW-1:0]);
    end
  end

  // Syndrome, its weight test, the twelve row tests and the second syndrome.
  always_comb begin
    mid_d.func = fn1_q;
    mid_d.hi   = hi1_q;
    mid_d.lo   = lo1_q;
    mid_d.pv   = pv1_q;
    mid_d.s    = hi1_q ^ pv1_q;
    mid_d.c1   = g24c_pkg::weight(mid_d.s) <= 4'd3;
    for (int c = 0; c < g24c_pkg::HalfW; c++) begin
      mid_d.m2[c] = g24c_pkg::weight(mid_d.s ^ g24c_pkg::GolayB[c]) <= 4'd2;
    end
    mid_d.q    = g24c_pkg::mul_b(mid_d.s);
  end

  // Stage 2 valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  // Stage 2 payload.
  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      mid_q <= mid_d;
    end
  end

  assign mid_valid_o = s2_valid_q;
  assign mid_o       = mid_q;

endmodule

// ===== sv/g24c_back.sv =====
`include "golay24_codec_assert.svh"

// Back half: stage 3 runs the tests on the second syndrome and resolves the
// second case, stage 4 picks the result and holds it for the receiver.
module g24c_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              mid_valid_i,
  output logic              mid_ready_o,
  input  g24c_pkg::mid_t    mid_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output g24c_pkg::word_t   result_o,
  output logic              ok_o
);

  typedef struct packed {
    g24c_pkg::func_e func;
    g24c_pkg::half_t hi;
    g24c_pkg::half_t lo;
    g24c_pkg::half_t pv;
    g24c_pkg::half_t msg1;
    logic            c1;
    logic            has2;
    g24c_pkg::half_t msg2;
    logic            c3;
    g24c_pkg::half_t m4;
  } tail_t;

  logic              s3_valid_q;
  logic              s3_ready;
  tail_t             tail_d;
  tail_t             tail_q;

  logic              out_valid_q;
  logic              s4_ready;
  g24c_pkg::word_t   result_d;
  g24c_pkg::word_t   result_q;
  logic              ok_d;
  logic              ok_q;
  g24c_pkg::half_t   msg4;

  assign s4_ready    = !out_valid_q || out_ready_i;
  assign s3_ready    = !s3_valid_q || s4_ready;
  assign mid_ready_o = s3_ready;

  // Weight tests on the second syndrome; the lowest matching row wins case two.
  always_comb begin
    tail_d.func = mid_i.func;
    tail_d.hi   = mid_i.hi;
    tail_d.lo   = mid_i.lo;
    tail_d.pv   = mid_i.pv;
    tail_d.msg1 = mid_i.hi ^ mid_i.s;
    tail_d.c1   = mid_i.c1;
    tail_d.has2 = |mid_i.m2;
    tail_d.msg2 = '0;
    for (int c = g24c_pkg::HalfW - 1; c >= 0; c--) begin
      if (mid_i.m2[c]) begin
        tail_d.msg2 = mid_i.hi ^ mid_i.s ^ g24c_pkg::GolayB[c];
      end
    end
    tail_d.c3   = g24c_pkg::weight(mid_i.q) <= 4'd3;
    for (int c = 0; c < g24c_pkg::HalfW; c++) begin
      tail_d.m4[c] = g24c_pkg::weight(mid_i.q ^ g24c_pkg::GolayB[c]) <= 4'd2;
    end
  end

  // Stage 3 valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (s3_ready) begin
      s3_valid_q <= mid_valid_i;
    end
  end

  // Stage 3 payload.
  always_ff @(posedge clk_i) begin
    if (s3_ready && mid_valid_i) begin
      tail_q <= tail_d;
    end
  end

  // Fourth case flips one message bit; then the cases are taken in order.
  always_comb begin
    msg4 = tail_q.hi;
    for (int c = g24c_pkg::HalfW - 1; c >= 0; c--) begin
      if (tail_q.m4[c]) begin
        msg4 = tail_q.hi;
        msg4[g24c_pkg::HalfW-1-c] = ~tail_q.hi[g24c_pkg::HalfW-1-c];
      end
    end
    result_d = '0;
    ok_d     = 1'b1;
    if (tail_q.func == g24c_pkg::FUNC_ENCODE) begin
      result_d = {tail_q.lo, tail_q.pv};
    end else if (tail_q.c1) begin
      result_d = {{g24c_pkg::HalfW{1'b0}}, tail_q.msg1};
    end else if (tail_q.has2) begin
      result_d = {{g24c_pkg::HalfW{1'b0}}, tail_q.msg2};
    end else if (tail_q.c3) begin
      result_d = {{g24c_pkg::HalfW{1'b0}}, tail_q.hi};
    end else if (|tail_q.m4) begin
      result_d = {{g24c_pkg::HalfW{1'b0}}, msg4};
    end else begin
      ok_d     = 1'b0;
    end
  end

  // Output register valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s4_ready) begin
      out_valid_q <= s3_valid_q;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (s4_ready && s3_valid_q) begin
      result_q <= result_d;
      ok_q     <= ok_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;
  assign ok_o        = ok_q;

  // An uncorrectable word leaves nothing in the result.
  `G24C_ASSERT(a_fail_zero, out_valid_q && !ok_q |-> result_q == '0)
  // Upper bits are set only by encode, which always succeeds.
  `G24C_ASSERT(a_upper_ok, out_valid_q && (result_q[g24c_pkg::WordW-1:g24c_pkg::HalfW] != '0) |-> ok_q)
  // A result appears only when stage 3 held a beat.
  `G24C_ASSERT(a_out_from_s3, $rose(out_valid_q) |-> $past(s3_valid_q))
  // Reset empties the output register and stage 3.
  `G24C_ASSERT_RST(a_reset_empty, !rst_ni |-> !out_valid_q && !s3_valid_q)

endmodule
